>>> design/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types, codes and constants of the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

	localparam int MAX_DIM  = 8;
	localparam int DIM_W    = 3;
	localparam int CNT_W    = 4;
	localparam int ADDR_W   = 2 * DIM_W;
	localparam int DEPTH    = 2 ** ADDR_W;
	localparam int ELEM_W   = 32;
	localparam int PROD_W   = 2 * ELEM_W;
	localparam int ACC_W    = PROD_W + 3;
	localparam int FRAC_W   = 16;

	localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_RUN    = 2'd2
	} op_e;

	typedef enum logic [1:0] {
		REG_A_ROWS = 2'd0,
		REG_A_COLS = 2'd1,
		REG_B_ROWS = 2'd2,
		REG_B_COLS = 2'd3
	} reg_idx_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_e;

	typedef struct packed {
		logic [1:0]              op;
		logic [DIM_W-1:0]        row_index;
		logic [DIM_W-1:0]        col_index;
		logic signed [ELEM_W-1:0] element;
	} req_item_t;

	typedef struct packed {
		logic [DIM_W-1:0]        out_row;
		logic [DIM_W-1:0]        out_col;
		logic signed [ELEM_W-1:0] product_value;
		logic                    saturated;
		logic                    last;
	} rsp_item_t;

	// controller to datapath
	typedef struct packed {
		logic              wr_a;
		logic              wr_b;
		logic [ADDR_W-1:0] wr_addr;
		logic              issue;
		logic              first;
		logic              last_k;
		logic              zero;
		logic              last_el;
		logic [DIM_W-1:0]  row;
		logic [DIM_W-1:0]  col;
		logic [DIM_W-1:0]  k;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic adv;
		logic busy;
	} stat_t;

	function automatic logic [CNT_W-1:0] clamp_dim(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] lim;
		lim = CNT_W'(MAX_DIM);
		return (v > lim) ? lim : v;
	endfunction

endpackage

>>> design/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Configuration registers, load decode and the run sequencer that steps
// row, column and inner index of the product.
// ----------------------------------------------------------------------------
module mme_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  mme_pkg::req_item_t            req_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [mme_pkg::CNT_W-1:0]     cfg_data,
	input  mme_pkg::stat_t                stat,
	output mme_pkg::cmd_t                 cmd
);

	mme_pkg::state_e state_q, state_d;

	logic [mme_pkg::CNT_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [mme_pkg::CNT_W-1:0] ar, ac, br, bc, inner;
	logic [mme_pkg::DIM_W-1:0] r_q, c_q, k_q;
	logic zero_mode, last_k, last_c, last_r, req_fire, run_go;

	always_comb begin
		ar        = mme_pkg::clamp_dim(a_rows_q);
		ac        = mme_pkg::clamp_dim(a_cols_q);
		br        = mme_pkg::clamp_dim(b_rows_q);
		bc        = mme_pkg::clamp_dim(b_cols_q);
		// mismatch or empty inner dimension: one step with a forced zero product
		zero_mode = (ac != br) || (ac == '0);
		inner     = zero_mode ? mme_pkg::CNT_W'(1) : ac;
		last_k    = ({1'b0, k_q} + mme_pkg::CNT_W'(1)) == inner;
		last_c    = ({1'b0, c_q} + mme_pkg::CNT_W'(1)) == bc;
		last_r    = ({1'b0, r_q} + mme_pkg::CNT_W'(1)) == ar;
		req_fire  = req_valid && req_ready;
		run_go    = req_fire && (req_item.op == mme_pkg::OP_RUN) &&
		            (ar != '0) && (bc != '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				if (run_go) state_d = mme_pkg::ST_RUN;
			end
			mme_pkg::ST_RUN: begin
				if (stat.adv && last_k && last_c && last_r) state_d = mme_pkg::ST_DRAIN;
			end
			mme_pkg::ST_DRAIN: begin
				if (!stat.busy) state_d = mme_pkg::ST_IDLE;
			end
			default: state_d = mme_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready   = (state_q == mme_pkg::ST_IDLE);
		cfg_ready   = 1'b1;
		cmd.wr_a    = req_fire && (req_item.op == mme_pkg::OP_LOAD_A) &&
		              ({1'b0, req_item.row_index} < ar) && ({1'b0, req_item.col_index} < ac);
		cmd.wr_b    = req_fire && (req_item.op == mme_pkg::OP_LOAD_B) &&
		              ({1'b0, req_item.row_index} < br) && ({1'b0, req_item.col_index} < bc);
		cmd.wr_addr = {req_item.row_index, req_item.col_index};
		cmd.issue   = (state_q == mme_pkg::ST_RUN) && stat.adv;
		cmd.first   = (k_q == '0);
		cmd.last_k  = last_k;
		cmd.zero    = zero_mode;
		cmd.last_el = last_k && last_c && last_r;
		cmd.row     = r_q;
		cmd.col     = c_q;
		cmd.k       = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// step inner index, then column, then row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
		end else if (run_go) begin
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
		end else if (cmd.issue) begin
			if (last_k) begin
				k_q <= '0;
				if (last_c) begin
					c_q <= '0;
					r_q <= r_q + mme_pkg::DIM_W'(1);
				end else begin
					c_q <= c_q + mme_pkg::DIM_W'(1);
				end
			end else begin
				k_q <= k_q + mme_pkg::DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q <= mme_pkg::CNT_W'(8);
			a_cols_q <= mme_pkg::CNT_W'(8);
			b_rows_q <= mme_pkg::CNT_W'(8);
			b_cols_q <= mme_pkg::CNT_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (mme_pkg::reg_idx_e'(cfg_index))
				mme_pkg::REG_A_ROWS: a_rows_q <= cfg_data;
				mme_pkg::REG_A_COLS: a_cols_q <= cfg_data;
				mme_pkg::REG_B_ROWS: b_rows_q <= cfg_data;
				mme_pkg::REG_B_COLS: b_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mme_pkg::ST_RUN) |-> ({1'b0, k_q} < inner))
		else $error("inner index beyond inner dimension");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		run_go |=> (state_q == mme_pkg::ST_RUN) && (r_q == '0) && (c_q == '0) && (k_q == '0))
		else $error("run did not start from the first element");
`endif

endmodule

>>> design/mme_dp.sv
// ----------------------------------------------------------------------------
// mme_dp
// Element stores, shared multiplier, exact accumulator, rounding and
// saturation, and the result register.
// ----------------------------------------------------------------------------
module mme_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mme_pkg::cmd_t        cmd,
	input  mme_pkg::req_item_t   req_item,
	output mme_pkg::stat_t       stat,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output mme_pkg::rsp_item_t   rsp_item
);

	logic signed [mme_pkg::ELEM_W-1:0] mem_a [mme_pkg::DEPTH];
	logic signed [mme_pkg::ELEM_W-1:0] mem_b [mme_pkg::DEPTH];

	logic adv;

	// stage 1: store read
	logic                              v_s1, first_s1, lastk_s1, zero_s1, lastel_s1;
	logic [mme_pkg::DIM_W-1:0]         row_s1, col_s1;
	logic signed [mme_pkg::ELEM_W-1:0] a_rd_s1, b_rd_s1;

	// stage 2: product
	logic                              v_s2, first_s2, lastk_s2, lastel_s2;
	logic [mme_pkg::DIM_W-1:0]         row_s2, col_s2;
	logic signed [mme_pkg::PROD_W-1:0] mul, prod_s2;

	// stage 3: accumulator
	logic                              done_s3, lastel_s3;
	logic [mme_pkg::DIM_W-1:0]         row_s3, col_s3;
	logic signed [mme_pkg::ACC_W-1:0]  acc_q, prod_ext;

	// rounding and saturation
	logic signed [mme_pkg::ACC_W-1:0]  rnd, shifted;
	logic                              over, under;
	logic signed [mme_pkg::ELEM_W-1:0] value;

	logic                              rsp_valid_q;
	mme_pkg::rsp_item_t                rsp_q;

	// whole pipeline holds while a result waits at the output
	assign adv       = !rsp_valid_q || rsp_ready;
	assign stat.adv  = adv;
	assign stat.busy = v_s1 || v_s2 || done_s3;

	always_ff @(posedge clk) begin
		if (cmd.wr_a) mem_a[cmd.wr_addr] <= req_item.element;
		if (adv) a_rd_s1 <= mem_a[{cmd.row, cmd.k}];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_b) mem_b[cmd.wr_addr] <= req_item.element;
		if (adv) b_rd_s1 <= mem_b[{cmd.k, cmd.col}];
	end

	always_comb begin
		mul      = mme_pkg::PROD_W'(a_rd_s1) * mme_pkg::PROD_W'(b_rd_s1);
		prod_ext = {{(mme_pkg::ACC_W - mme_pkg::PROD_W){prod_s2[mme_pkg::PROD_W-1]}}, prod_s2};
		rnd      = acc_q + mme_pkg::ACC_W'(1 << (mme_pkg::FRAC_W - 1));
		shifted  = rnd >>> mme_pkg::FRAC_W;
		over     = !shifted[mme_pkg::ACC_W-1] &&
		           (|shifted[mme_pkg::ACC_W-1:mme_pkg::ELEM_W-1]);
		under    = shifted[mme_pkg::ACC_W-1] &&
		           !(&shifted[mme_pkg::ACC_W-1:mme_pkg::ELEM_W-1]);
		priority if (over) value = mme_pkg::ELEM_MAX;
		else if (under)    value = mme_pkg::ELEM_MIN;
		else               value = shifted[mme_pkg::ELEM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			done_s3     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= cmd.issue;
			v_s2        <= v_s1;
			done_s3     <= v_s2 && lastk_s2;
			rsp_valid_q <= done_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s1  <= cmd.first;
			lastk_s1  <= cmd.last_k;
			zero_s1   <= cmd.zero;
			lastel_s1 <= cmd.last_el;
			row_s1    <= cmd.row;
			col_s1    <= cmd.col;

			first_s2  <= first_s1;
			lastk_s2  <= lastk_s1;
			lastel_s2 <= lastel_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			prod_s2   <= zero_s1 ? '0 : mul;

			lastel_s3 <= lastel_s2;
			row_s3    <= row_s2;
			col_s3    <= col_s2;
			if (v_s2) acc_q <= first_s2 ? prod_ext : acc_q + prod_ext;

			if (done_s3) begin
				rsp_q.out_row       <= row_s3;
				rsp_q.out_col       <= col_s3;
				rsp_q.product_value <= value;
				rsp_q.saturated     <= over || under;
				rsp_q.last          <= lastel_s3;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

`ifndef NO_ASSERTIONS
	a_sat_clipped: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_item.saturated) |->
		((rsp_item.product_value == mme_pkg::ELEM_MAX) ||
		 (rsp_item.product_value == mme_pkg::ELEM_MIN)))
		else $error("saturated result not at a range limit");

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && v_s2) |=> $stable(acc_q))
		else $error("accumulator moved during stall");

	a_zero_product: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1 && zero_s1) |=> (prod_s2 == '0))
		else $error("mismatch step produced a nonzero product");
`endif

endmodule

>>> design/matrix_multiply_engine.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Loads matrices A and B element by element and streams C = A x B.
// ----------------------------------------------------------------------------
// A load request (op load A or load B) is ignored when its row or column lies
// outside the configured size of its matrix. A run request streams C in
// row-major order with last set on the final element; it keeps the request side
// busy until every product has issued and the pipeline has drained, since one
// 32x32 multiplier feeds one exact 67-bit accumulator with one product per cycle
// while the result side is not stalled. When a_cols differs from b_rows or is
// zero the run streams zeros, one product step per element. Each element is
// rounded half up to Q16.16 and saturated, with saturated flagging clipping.
// Backpressure on the result side pauses the whole run. Size registers above 8
// act as 8; a run with zero A rows or zero B columns returns nothing.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  mme_pkg::req_item_t            req_item,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output mme_pkg::rsp_item_t            rsp_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [mme_pkg::CNT_W-1:0]     cfg_data
);

	mme_pkg::cmd_t  cmd;
	mme_pkg::stat_t stat;

	mme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.cmd       (cmd)
	);

	mme_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_item  (req_item),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item)
	);

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for matrix_multiply_engine.
// Loads A and B through the request channel and sets the matrix sizes through
// the register port. A shadow of both stores and of the size registers
// predicts every C element, with exact sums, half-up rounding and saturation.
// Each returned element is compared field by field against the oldest
// prediction. A short directed pass covers the saturation corners, rounding
// ties, ignored loads, the spare op, size mismatch and zero sizes. Random
// phases then pick new sizes and issue load sets followed by runs, while both
// sides idle at several rates.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mme_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 16;
	// longest correct silence is a stalled result or the drain wait; allow plenty
	localparam int QUIET_LIMIT = 4000;
	localparam logic signed [71:0] ROUND_HALF = 72'sd32768;
	localparam logic signed [71:0] SUM_MAX = 72'sd2147483647;
	localparam logic signed [71:0] SUM_MIN = -72'sd2147483648;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_ready;
	req_item_t  req_item = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	rsp_item_t  rsp_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [CNT_W-1:0] cfg_data = '0;

	// sizes in force, shared by stimulus and prediction (changed only when idle)
	logic [CNT_W-1:0] shape_reg [4];
	logic signed [ELEM_W-1:0] a_store [MAX_DIM*MAX_DIM];
	logic signed [ELEM_W-1:0] b_store [MAX_DIM*MAX_DIM];
	bit a_written [MAX_DIM*MAX_DIM];
	bit b_written [MAX_DIM*MAX_DIM];

	req_item_t request_backlog [$];
	req_item_t load_batch [$];
	rsp_item_t product_due [$];

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int useful_count = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;

	matrix_multiply_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_item  (rsp_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int used_dim(input logic [CNT_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : int'(v);
	endfunction

	function automatic logic signed [ELEM_W-1:0] pick_element();
		int p;
		logic signed [ELEM_W-1:0] v;
		p = $urandom_range(99);
		if (p < 35)
			return $urandom();
		if (p < 45) begin
			case ($urandom_range(4))
				0: return ELEM_MAX;
				1: return ELEM_MIN;
				2: return 0;
				3: return 1;
				default: return -1;
			endcase
		end
		// about -4.0 .. +4.0
		v = 32'($urandom_range(32'h7FFFF));
		return v - 32'sh0004_0000;
	endfunction

	function automatic logic [CNT_W-1:0] pick_dim();
		int p;
		p = $urandom_range(99);
		if (p < 4)
			return '0;
		if (p < 14)
			return CNT_W'($urandom_range(8, 15));
		return CNT_W'($urandom_range(1, 4));
	endfunction

	task automatic report_mismatch(input string what);
		$display("tb mismatch at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic write_reg(input reg_idx_e idx, input logic [CNT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shape_reg[idx] = val;
	endtask

	// queue one request and note which store entries it fills
	task automatic push_item(input logic [1:0] op, input int row, input int col,
			input logic signed [ELEM_W-1:0] value);
		req_item_t it;
		it.op        = op;
		it.row_index = DIM_W'(row);
		it.col_index = DIM_W'(col);
		it.element   = value;
		if (op == OP_LOAD_A && row < used_dim(shape_reg[REG_A_ROWS])
				&& col < used_dim(shape_reg[REG_A_COLS])) begin
			a_written[{it.row_index, it.col_index}] = 1'b1;
			useful_count++;
		end else if (op == OP_LOAD_B && row < used_dim(shape_reg[REG_B_ROWS])
				&& col < used_dim(shape_reg[REG_B_COLS])) begin
			b_written[{it.row_index, it.col_index}] = 1'b1;
			useful_count++;
		end else if (op == OP_RUN) begin
			useful_count++;
		end
		load_batch.push_back(it);
	endtask

	task automatic commit_batch(input bit mix);
		int j;
		req_item_t tmp;
		if (mix) begin
			for (int i = load_batch.size() - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = load_batch[i];
				load_batch[i] = load_batch[j];
				load_batch[j] = tmp;
			end
		end
		foreach (load_batch[i])
			request_backlog.push_back(load_batch[i]);
		load_batch.delete();
	endtask

	task automatic wait_idle();
		while (request_backlog.size() != 0 || req_valid || product_due.size() != 0)
			@(negedge clk);
		// a trailing load or an empty run may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic predict_products(input req_item_t it);
		int ar, ac, br, bc;
		logic signed [71:0] acc;
		rsp_item_t want;
		ar = used_dim(shape_reg[REG_A_ROWS]);
		ac = used_dim(shape_reg[REG_A_COLS]);
		br = used_dim(shape_reg[REG_B_ROWS]);
		bc = used_dim(shape_reg[REG_B_COLS]);
		case (it.op)
			OP_LOAD_A: begin
				if (it.row_index < ar && it.col_index < ac)
					a_store[{it.row_index, it.col_index}] = it.element;
			end
			OP_LOAD_B: begin
				if (it.row_index < br && it.col_index < bc)
					b_store[{it.row_index, it.col_index}] = it.element;
			end
			OP_RUN: begin
				for (int r = 0; r < ar; r++) begin
					for (int c = 0; c < bc; c++) begin
						acc = '0;
						// mismatched inner sizes leave the sum at zero
						if (ac == br) begin
							for (int k = 0; k < ac; k++)
								acc = acc + 72'(a_store[r*MAX_DIM + k]) *
									72'(b_store[k*MAX_DIM + c]);
						end
						acc = (acc + ROUND_HALF) >>> FRAC_W;
						want.saturated = 1'b0;
						if (acc > SUM_MAX) begin
							acc = SUM_MAX;
							want.saturated = 1'b1;
						end else if (acc < SUM_MIN) begin
							acc = SUM_MIN;
							want.saturated = 1'b1;
						end
						want.out_row       = DIM_W'(r);
						want.out_col       = DIM_W'(c);
						want.product_value = acc[ELEM_W-1:0];
						want.last          = (r == ar - 1) && (c == bc - 1);
						product_due.push_back(want);
					end
				end
			end
			default: ;
		endcase
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_item  <= '0;
		end else begin
			if (req_valid && req_ready)
				predict_products(req_item);
			if (!req_valid || req_ready) begin
				if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_item  <= request_backlog.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (product_due.size() == 0) begin
					report_mismatch($sformatf("element (%0d,%0d) with nothing due",
						rsp_item.out_row, rsp_item.out_col));
				end else begin
					want = product_due.pop_front();
					if (rsp_item.out_row !== want.out_row)
						report_mismatch($sformatf("out_row %0d, want %0d",
							rsp_item.out_row, want.out_row));
					if (rsp_item.out_col !== want.out_col)
						report_mismatch($sformatf("out_col %0d, want %0d",
							rsp_item.out_col, want.out_col));
					if (rsp_item.product_value !== want.product_value)
						report_mismatch($sformatf("(%0d,%0d) product_value %h, want %h",
							want.out_row, want.out_col, rsp_item.product_value,
							want.product_value));
					if (rsp_item.saturated !== want.saturated)
						report_mismatch($sformatf("(%0d,%0d) saturated %b, want %b",
							want.out_row, want.out_col, rsp_item.saturated, want.saturated));
					if (rsp_item.last !== want.last)
						report_mismatch($sformatf("(%0d,%0d) last %b, want %b",
							want.out_row, want.out_col, rsp_item.last, want.last));
				end
			end
			rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// end the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic random_phase(input int phase_no);
		logic [CNT_W-1:0] dims [4];
		int ar, ac, br, bc, p;
		if (phase_no == 0) begin
			// full size, with A row and column counts above the limit acting as eight
			dims[REG_A_ROWS] = 4'd15;
			dims[REG_A_COLS] = 4'd15;
			dims[REG_B_ROWS] = 4'd8;
			dims[REG_B_COLS] = 4'd8;
		end else begin
			dims[REG_A_ROWS] = pick_dim();
			dims[REG_A_COLS] = pick_dim();
			dims[REG_B_COLS] = pick_dim();
			if ($urandom_range(99) < 85) begin
				dims[REG_B_ROWS] = (used_dim(dims[REG_A_COLS]) == MAX_DIM) ?
					CNT_W'($urandom_range(8, 15)) : dims[REG_A_COLS];
			end else begin
				dims[REG_B_ROWS] = pick_dim();
			end
		end
		case (phase_no % 4)
			0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
			1: begin send_idle_pct = 85; rsp_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  rsp_stall_pct = 85; end
			default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
		endcase
		for (int i = 0; i < 4; i++)
			write_reg(reg_idx_e'(i), dims[i]);
		ar = used_dim(dims[REG_A_ROWS]);
		ac = used_dim(dims[REG_A_COLS]);
		br = used_dim(dims[REG_B_ROWS]);
		bc = used_dim(dims[REG_B_COLS]);
		repeat ($urandom_range(1, 3)) begin
			// fill every entry the run reads, refresh some others
			for (int r = 0; r < ar; r++)
				for (int c = 0; c < ac; c++)
					if (!a_written[r*MAX_DIM + c] || $urandom_range(99) < 35)
						push_item(OP_LOAD_A, r, c, pick_element());
			for (int r = 0; r < br; r++)
				for (int c = 0; c < bc; c++)
					if (!b_written[r*MAX_DIM + c] || $urandom_range(99) < 35)
						push_item(OP_LOAD_B, r, c, pick_element());
			repeat ($urandom_range(3)) begin
				p = $urandom_range(2);
				if (p == 1 && ar < MAX_DIM)
					push_item(OP_LOAD_A, $urandom_range(ar, 7), $urandom_range(7), pick_element());
				else if (p == 1 && ac < MAX_DIM)
					push_item(OP_LOAD_A, $urandom_range(7), $urandom_range(ac, 7), pick_element());
				else if (p == 2 && br < MAX_DIM)
					push_item(OP_LOAD_B, $urandom_range(br, 7), $urandom_range(7), pick_element());
				else if (p == 2 && bc < MAX_DIM)
					push_item(OP_LOAD_B, $urandom_range(7), $urandom_range(bc, 7), pick_element());
				else
					push_item(OP_SPARE, $urandom_range(7), $urandom_range(7), pick_element());
			end
			commit_batch(1'b1);
			push_item(OP_RUN, $urandom_range(7), $urandom_range(7), pick_element());
			commit_batch(1'b0);
		end
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < 4; i++)
			shape_reg[i] = 4'd8;
		foreach (a_store[i]) begin
			a_store[i] = '0;
			b_store[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// 2x2: saturation both ways, plain products, ignored loads, spare op
		write_reg(REG_A_ROWS, 4'd2);
		write_reg(REG_A_COLS, 4'd2);
		write_reg(REG_B_ROWS, 4'd2);
		write_reg(REG_B_COLS, 4'd2);
		push_item(OP_LOAD_A, 0, 0, ELEM_MAX);
		push_item(OP_LOAD_A, 0, 1, ELEM_MAX);
		push_item(OP_LOAD_A, 1, 0, ELEM_MIN);
		push_item(OP_LOAD_A, 1, 1, ELEM_MIN);
		push_item(OP_LOAD_B, 0, 0, ELEM_MAX);
		push_item(OP_LOAD_B, 1, 0, ELEM_MAX);
		push_item(OP_LOAD_B, 0, 1, 32'sd1);
		push_item(OP_LOAD_B, 1, 1, 32'sh8000);
		push_item(OP_LOAD_A, 2, 0, 32'sh1234_5678);
		push_item(OP_LOAD_B, 0, 7, -32'sd1);
		push_item(OP_SPARE, 7, 7, ELEM_MIN);
		push_item(OP_RUN, 0, 0, 32'sd0);
		commit_batch(1'b0);
		wait_idle();

		// inner sizes disagree: all zeros
		write_reg(REG_A_COLS, 4'd3);
		push_item(OP_RUN, 7, 7, ELEM_MAX);
		commit_batch(1'b0);
		wait_idle();

		// 1x1: rounding ties up from both signs, product of two minimums
		write_reg(REG_A_ROWS, 4'd1);
		write_reg(REG_A_COLS, 4'd1);
		write_reg(REG_B_ROWS, 4'd1);
		write_reg(REG_B_COLS, 4'd1);
		push_item(OP_LOAD_A, 0, 0, 32'sh8000);
		push_item(OP_LOAD_B, 0, 0, 32'sd1);
		push_item(OP_RUN, 0, 0, 32'sd0);
		push_item(OP_LOAD_A, 0, 0, -32'sh8000);
		push_item(OP_RUN, 0, 0, 32'sd0);
		push_item(OP_LOAD_A, 0, 0, ELEM_MIN);
		push_item(OP_LOAD_B, 0, 0, ELEM_MIN);
		push_item(OP_RUN, 0, 0, 32'sd0);
		commit_batch(1'b0);
		wait_idle();

		// zero rows: nothing back; zero inner size: one zero element
		write_reg(REG_A_ROWS, 4'd0);
		push_item(OP_RUN, 0, 0, 32'sd0);
		commit_batch(1'b0);
		wait_idle();
		write_reg(REG_A_ROWS, 4'd1);
		write_reg(REG_A_COLS, 4'd0);
		write_reg(REG_B_ROWS, 4'd0);
		push_item(OP_RUN, 0, 0, 32'sd0);
		commit_batch(1'b0);
		wait_idle();

		for (int n = 0; useful_count < 500; n++)
			random_phase(n);

		send_idle_pct = 0;
		rsp_stall_pct = 0;
		wait_idle();
		if (mismatch_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
